// File: sv/ppfc_pkg.sv
// Shared types, codes and color conversion functions for the palette pixel format converter.
package ppfc_pkg;

    localparam int PIX_W = 24;
    localparam int IDX_W = 8;

    // Item kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Source formats
    localparam logic [2:0] SRC_PAL = 3'd0;
    localparam logic [2:0] SRC_555 = 3'd1;
    localparam logic [2:0] SRC_565 = 3'd2;
    localparam logic [2:0] SRC_888 = 3'd3;

    // Destination formats
    localparam logic [1:0] DST_555 = 2'd0;
    localparam logic [1:0] DST_565 = 2'd1;
    localparam logic [1:0] DST_888 = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SRC_FMT = 1'b0;
    localparam logic CFG_DST_FMT = 1'b1;

    localparam logic [2:0] SRC_FMT_RST = SRC_888;
    localparam logic [1:0] DST_FMT_RST = DST_888;

    // Palette access requests for one accepted transaction
    typedef struct packed {
        logic             wr;
        logic             clr;
        logic             rd;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx;
        logic [PIX_W-1:0] wr_data;
    } t_pal_req;

    function automatic logic [PIX_W-1:0] f_widen565(logic [15:0] p);
        return {p[15:11], p[15:13], p[10:5], p[10:9], p[4:0], p[4:2]};
    endfunction

    function automatic logic [PIX_W-1:0] f_widen555(logic [15:0] p);
        return {p[14:10], p[14:12], p[9:5], p[9:7], p[4:0], p[4:2]};
    endfunction

    function automatic logic [PIX_W-1:0] f_narrow565(logic [PIX_W-1:0] c);
        return {8'h00, c[23:19], c[15:10], c[7:3]};
    endfunction

    function automatic logic [PIX_W-1:0] f_narrow555(logic [PIX_W-1:0] c);
        return {9'h000, c[23:19], c[15:11], c[7:3]};
    endfunction

    function automatic logic [PIX_W-1:0] f_convert(
        logic [2:0]       src,
        logic [1:0]       dst,
        logic [PIX_W-1:0] pix,
        logic [PIX_W-1:0] pal
    );
        logic [PIX_W-1:0] res;
        res = pix;
        case (dst)
            DST_888: begin
                case (src)
                    SRC_888: res = pix;
                    SRC_565: res = f_widen565(pix[15:0]);
                    SRC_555: res = f_widen555(pix[15:0]);
                    SRC_PAL: res = pal;
                    default: res = pix;
                endcase
            end
            DST_565: begin
                case (src)
                    SRC_555: res = f_narrow565(f_widen555(pix[15:0]));
                    SRC_PAL: res = f_narrow565(pal);
                    default: res = pix;
                endcase
            end
            DST_555: begin
                case (src)
                    SRC_PAL: res = f_narrow555(pal);
                    default: res = pix;
                endcase
            end
            default: res = pix;
        endcase
        return res;
    endfunction

endpackage

// File: sv/ppfc_palette.sv
// Palette memory with per-entry valid flags and registered read.
module ppfc_palette #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ppfc_pkg::t_pal_req      i_req,
    output logic [ppfc_pkg::PIX_W-1:0] o_rd_data
);
    import ppfc_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [PIX_W-1:0]           mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_valid;
    logic [PIX_W-1:0]           r_rd_data;
    logic                       r_rd_hit;
    logic                       wr_in_range;
    logic                       rd_in_range;

    assign wr_in_range = {1'b0, i_req.wr_idx} < (IDX_W + 1)'(PALETTE_ENTRIES);
    assign rd_in_range = {1'b0, i_req.rd_idx} < (IDX_W + 1)'(PALETTE_ENTRIES);

    // Payload storage: written and read in the same clocked block
    always_ff @(posedge i_clk) begin
        if (i_req.wr && wr_in_range) begin
            mem[i_req.wr_idx[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd) begin
            r_rd_data <= mem[i_req.rd_idx[AW-1:0]];
        end
    end

    // An entry never written since reset or the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.wr && wr_in_range) begin
                r_valid[i_req.wr_idx[AW-1:0]] <= 1'b1;
            end
            if (i_req.rd) begin
                r_rd_hit <= rd_in_range && r_valid[i_req.rd_idx[AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// File: sv/palette_pixel_format_converter_top.sv
// Top level of the palette pixel format converter.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per item:
//   kind selects convert pixel, write palette entry or clear palette.
//   Only convert transactions produce a result on the output channel
//   (o_out_valid / i_out_ready): the converted pixel and its frame_end flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes source_format
//   (index 0) and dest_format (index 1); it is always ready. Change the
//   formats only while no pixel is in flight.
// Throughput and ordering:
//   One transaction per cycle while the receiver keeps up. An accepted pixel
//   and its palette read are registered in the read stage, then the converted
//   pixel loads into the output register. Palette writes and clears take
//   effect at acceptance, so a following pixel sees them.
// Stall behavior:
//   A stalled receiver holds the output register; the next pixel waits in the
//   read stage, and the input backs up only when both are full.
// Reset:
//   Synchronous, active low. Pipeline emptied, all palette entries read as
//   zero at once (valid flags cleared), formats return to rgb888 to xrgb888.
module palette_pixel_format_converter_top #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input transactions
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_kind,
    input  logic [ppfc_pkg::PIX_W-1:0] i_pixel_value,
    input  logic                       i_frame_end,
    input  logic [ppfc_pkg::IDX_W-1:0] i_palette_index,
    input  logic [7:0]                 i_red_in,
    input  logic [7:0]                 i_green_in,
    input  logic [7:0]                 i_blue_in,
    // result transactions
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ppfc_pkg::PIX_W-1:0] o_out_pixel,
    output logic                       o_out_last,
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [2:0]                 i_cfg_data
);
    import ppfc_pkg::*;

    logic [2:0]       r_src_fmt;
    logic [1:0]       r_dst_fmt;

    // read stage: pixel waiting on palette data
    logic             r_s1_vld;
    logic [PIX_W-1:0] r_s1_pixel;
    logic             r_s1_last;

    // output register
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_last;

    logic             in_acc;
    logic             pix_acc;
    logic             s1_adv;
    logic             cfg_acc;
    logic [PIX_W-1:0] pal_data;
    logic [PIX_W-1:0] n_out_pixel;
    t_pal_req         pal_req;

    // Advance the read stage when the output register is empty or being taken
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign pix_acc    = in_acc && (i_kind == KIND_PIXEL);

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // Palette requests: at most one of write, clear, read per cycle
    always_comb begin
        pal_req.wr      = in_acc && (i_kind == KIND_WRITE);
        pal_req.clr     = in_acc && (i_kind == KIND_CLEAR);
        pal_req.rd      = pix_acc;
        pal_req.wr_idx  = i_palette_index;
        pal_req.rd_idx  = i_pixel_value[IDX_W-1:0];
        pal_req.wr_data = {i_red_in, i_green_in, i_blue_in};
    end

    ppfc_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (pal_req),
        .o_rd_data (pal_data)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= SRC_FMT_RST;
            r_dst_fmt <= DST_FMT_RST;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                CFG_SRC_FMT: r_src_fmt <= i_cfg_data;
                CFG_DST_FMT: r_dst_fmt <= i_cfg_data[1:0];
                default:     r_src_fmt <= r_src_fmt;
            endcase
        end
    end

    // Palette data lines up with the pixel held in the read stage
    assign n_out_pixel = f_convert(r_src_fmt, r_dst_fmt, r_s1_pixel, pal_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (pix_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_pixel <= i_pixel_value;
            r_s1_last  <= i_frame_end;
        end
        if (s1_adv) begin
            r_out_pixel <= n_out_pixel;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_pixel = r_out_pixel;
    assign o_out_last  = r_out_last;

    // A pixel enters the read stage only from an accepted convert transaction
    a_s1_from_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s1_vld) |-> $past(pix_acc))
        else $error("read stage filled without a convert transaction");

    // Input backs up only when both stages hold a pixel
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_vld && r_out_vld))
        else $error("input stalled with a free stage");

    // A blocked read stage keeps its pixel
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_s1_pixel) && $stable(r_s1_last)))
        else $error("read stage lost a pixel while stalled");

endmodule
